// ----- rtl/core/tksr_pkg.sv -----
// Shared types, phase codes, register indexes and reset values for the touch keypad reader.
`timescale 1ns / 1ps

package tksr_pkg;

    localparam int MAX_KEYS_DEF = 16;

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    localparam logic [2:0] REG_SIXTEEN_KEYS   = 3'd0;
    localparam logic [2:0] REG_REPORT_INDEX   = 3'd1;
    localparam logic [2:0] REG_DETECT_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_HALF_PERIOD    = 3'd3;
    localparam logic [2:0] REG_SETTLE_TICKS   = 3'd4;
    localparam logic [2:0] REG_GAP_TICKS      = 3'd5;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_WAIT_LOW  = 3'd1;
    localparam logic [2:0] PH_WAIT_HIGH = 3'd2;
    localparam logic [2:0] PH_SETTLE    = 3'd3;
    localparam logic [2:0] PH_CLK_LOW   = 3'd4;
    localparam logic [2:0] PH_CLK_HIGH  = 3'd5;
    localparam logic [2:0] PH_GAP       = 3'd6;

    localparam logic [15:0] RST_DETECT_TIMEOUT = 16'd50000;
    localparam logic [7:0]  RST_HALF_PERIOD    = 8'd2;
    localparam logic [9:0]  RST_SETTLE_TICKS   = 10'd10;
    localparam logic [15:0] RST_GAP_TICKS      = 16'd2000;

    typedef struct packed {
        logic        sixteen_keys;
        logic        report_index;
        logic [15:0] detect_timeout;
        logic [7:0]  half_period;
        logic [9:0]  settle_ticks;
        logic [15:0] gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] tick_count;
        logic [4:0]  bit_number;
        logic [15:0] collected;
        logic [15:0] last_keys;
        logic        clock_reg;
    } t_state;

    typedef struct packed {
        t_state st;
        logic   result_valid;
        logic   timed_out;
    } t_step_out;

endpackage

// ----- rtl/core/tksr_cfg.sv -----
// Configuration register bank with a simple APB-style access port.
`timescale 1ns / 1ps

module tksr_cfg
    import tksr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sixteen_keys   <= 1'b1;
            r_cfg.report_index   <= 1'b0;
            r_cfg.detect_timeout <= RST_DETECT_TIMEOUT;
            r_cfg.half_period    <= RST_HALF_PERIOD;
            r_cfg.settle_ticks   <= RST_SETTLE_TICKS;
            r_cfg.gap_ticks      <= RST_GAP_TICKS;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SIXTEEN_KEYS:   r_cfg.sixteen_keys   <= pwdata[0];
                REG_REPORT_INDEX:   r_cfg.report_index   <= pwdata[0];
                REG_DETECT_TIMEOUT: r_cfg.detect_timeout <= pwdata[15:0];
                REG_HALF_PERIOD:    r_cfg.half_period    <= pwdata[7:0];
                REG_SETTLE_TICKS:   r_cfg.settle_ticks   <= pwdata[9:0];
                REG_GAP_TICKS:      r_cfg.gap_ticks      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SIXTEEN_KEYS:   prdata = {31'd0, r_cfg.sixteen_keys};
            REG_REPORT_INDEX:   prdata = {31'd0, r_cfg.report_index};
            REG_DETECT_TIMEOUT: prdata = {16'd0, r_cfg.detect_timeout};
            REG_HALF_PERIOD:    prdata = {24'd0, r_cfg.half_period};
            REG_SETTLE_TICKS:   prdata = {22'd0, r_cfg.settle_ticks};
            REG_GAP_TICKS:      prdata = {16'd0, r_cfg.gap_ticks};
            default:            prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/tksr_step.sv -----
// Next-state logic for one tick of the serial key read sequence.
`timescale 1ns / 1ps

module tksr_step
    import tksr_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
)
(
    input  t_state    i_cur,
    input  t_cfg      i_cfg,
    input  logic      i_data_level,
    input  logic      i_start_req,
    output t_step_out o_nxt
);

    localparam logic [4:0] MaxK = 5'(MAX_KEYS);

    logic [15:0] tick_inc;
    logic [15:0] det_lim;
    logic [15:0] half_len;
    logic [4:0]  bit_inc;
    logic [4:0]  key_bits;
    logic [4:0]  nominal_bits;
    logic [4:0]  top_idx;
    logic [15:0] report_val;

    assign tick_inc     = i_cur.tick_count + 16'd1;
    assign det_lim      = (i_cfg.detect_timeout == 16'd0) ? 16'd1 : i_cfg.detect_timeout;
    assign half_len     = (i_cfg.half_period == 8'd0) ? 16'd1 : {8'd0, i_cfg.half_period};
    assign bit_inc      = i_cur.bit_number + 5'd1;
    assign nominal_bits = i_cfg.sixteen_keys ? 5'd16 : 5'd8;
    assign key_bits     = (nominal_bits < MaxK) ? nominal_bits : MaxK;

    always_comb begin
        top_idx = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (i_cur.collected[i]) begin
                top_idx = 5'(i + 1);
            end
        end
    end

    assign report_val = i_cfg.report_index ? {11'd0, top_idx} : i_cur.collected;

    always_comb begin
        o_nxt.st           = i_cur;
        o_nxt.result_valid = 1'b0;
        o_nxt.timed_out    = 1'b0;

        unique case (i_cur.phase)
            PH_IDLE: begin
                o_nxt.st.clock_reg = 1'b1;
                if (i_start_req) begin
                    o_nxt.st.phase      = PH_WAIT_LOW;
                    o_nxt.st.tick_count = '0;
                    o_nxt.st.bit_number = '0;
                    o_nxt.st.collected  = '0;
                end
            end
            PH_WAIT_LOW, PH_WAIT_HIGH: begin
                if ((i_cur.phase == PH_WAIT_LOW) && !i_data_level) begin
                    o_nxt.st.phase = PH_WAIT_HIGH;
                end else if ((i_cur.phase == PH_WAIT_HIGH) && i_data_level) begin
                    o_nxt.st.tick_count = '0;
                    if (i_cfg.settle_ticks == 10'd0) begin
                        o_nxt.st.phase      = PH_CLK_LOW;
                        o_nxt.st.bit_number = '0;
                        o_nxt.st.collected  = '0;
                        o_nxt.st.clock_reg  = 1'b0;
                    end else begin
                        o_nxt.st.phase = PH_SETTLE;
                    end
                end else begin
                    o_nxt.st.tick_count = tick_inc;
                    if (tick_inc >= det_lim) begin
                        o_nxt.timed_out     = 1'b1;
                        o_nxt.st.phase      = PH_IDLE;
                        o_nxt.st.tick_count = '0;
                        o_nxt.st.clock_reg  = 1'b1;
                    end
                end
            end
            PH_SETTLE: begin
                o_nxt.st.tick_count = tick_inc;
                if (tick_inc >= {6'd0, i_cfg.settle_ticks}) begin
                    o_nxt.st.phase      = PH_CLK_LOW;
                    o_nxt.st.tick_count = '0;
                    o_nxt.st.bit_number = '0;
                    o_nxt.st.collected  = '0;
                    o_nxt.st.clock_reg  = 1'b0;
                end
            end
            PH_CLK_LOW: begin
                o_nxt.st.tick_count = tick_inc;
                if (tick_inc >= half_len) begin
                    if (!i_data_level) begin
                        o_nxt.st.collected[i_cur.bit_number[3:0]] = 1'b1;
                    end
                    o_nxt.st.clock_reg  = 1'b1;
                    o_nxt.st.phase      = PH_CLK_HIGH;
                    o_nxt.st.tick_count = '0;
                end
            end
            PH_CLK_HIGH: begin
                o_nxt.st.tick_count = tick_inc;
                if (tick_inc >= half_len) begin
                    o_nxt.st.bit_number = bit_inc;
                    o_nxt.st.tick_count = '0;
                    if (bit_inc >= key_bits) begin
                        if (i_cfg.gap_ticks == 16'd0) begin
                            o_nxt.st.last_keys = report_val;
                            o_nxt.result_valid = 1'b1;
                            o_nxt.st.phase     = PH_IDLE;
                            o_nxt.st.clock_reg = 1'b1;
                        end else begin
                            o_nxt.st.phase = PH_GAP;
                        end
                    end else begin
                        o_nxt.st.clock_reg = 1'b0;
                        o_nxt.st.phase     = PH_CLK_LOW;
                    end
                end
            end
            PH_GAP: begin
                o_nxt.st.tick_count = tick_inc;
                if (tick_inc >= i_cfg.gap_ticks) begin
                    o_nxt.st.last_keys  = report_val;
                    o_nxt.result_valid  = 1'b1;
                    o_nxt.st.phase      = PH_IDLE;
                    o_nxt.st.tick_count = '0;
                    o_nxt.st.clock_reg  = 1'b1;
                end
            end
            default: begin
                o_nxt.st.phase      = PH_IDLE;
                o_nxt.st.tick_count = '0;
                o_nxt.st.clock_reg  = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/core/touch_keypad_serial_reader.sv -----
// Top level of the touch keypad serial reader: tick input stage, sequencer state and result stage.
//
//   Channel   Direction  Transfer                      Contents
//   s_axis    in         one tick                      tdata: data_level, start_req
//   m_axis    out        one result per tick           tdata: clock, busy, valid, timeout, keys
//   APB       in/out     register write or read        six configuration registers
//
// Each tick passes through the input register and then through the sequencer logic into the
// result register; a tick may be accepted every cycle while the result stage is not stalled.
// Reset is synchronous and active low; it returns the sequencer to idle with the clock line high.
// A stalled result stage holds the sequencer and, once the input register is full, the input.
`timescale 1ns / 1ps

module touch_keypad_serial_reader
    import tksr_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,  // [0] data_level, [1] start_req
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,  // [0] clock_level, [1] busy_res, [2] result_valid,
                                             // [3] timed_out, [19:4] keys
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    t_state     r_state;
    t_step_out  n_step;
    logic       r_in_valid;
    logic [1:0] r_in_data;
    logic       r_out_valid;
    logic [23:0] r_out_data;
    logic       fire;
    logic [23:0] n_out_data;

    tksr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tksr_step #(
        .MAX_KEYS (MAX_KEYS)
    ) u_step (
        .i_cur        (r_state),
        .i_cfg        (cfg),
        .i_data_level (r_in_data[0]),
        .i_start_req  (r_in_data[1]),
        .o_nxt        (n_step)
    );

    assign fire          = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | fire;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign n_out_data = {4'd0, n_step.st.last_keys, n_step.timed_out, n_step.result_valid,
                         (n_step.st.phase != PH_IDLE), n_step.st.clock_reg};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata[1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_IDLE;
            r_state.tick_count <= '0;
            r_state.bit_number <= '0;
            r_state.collected  <= '0;
            r_state.last_keys  <= '0;
            r_state.clock_reg  <= 1'b1;
        end else if (fire) begin
            r_state <= n_step.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= n_out_data;
        end
    end

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[2] && r_out_data[3]))
        else $error("result and timeout flagged on the same tick");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data[2] || r_out_data[3])) |-> !r_out_data[1])
        else $error("read reported finished while still busy");

    a_clock_low_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> r_out_data[1])
        else $error("clock line driven low while idle");

    a_keys_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !n_step.result_valid) |=> (r_state.last_keys == $past(r_state.last_keys)))
        else $error("stored keys changed without a completed read");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_state.phase == PH_IDLE) && !r_in_data[1]) |=> (r_state.phase == PH_IDLE))
        else $error("sequencer left idle without a start request");

endmodule

// ----- tb/sv/tb_touch_keypad_serial_reader.sv -----
// Self-checking testbench for the touch keypad serial reader, with its own model of the reader.
`timescale 1ns / 1ps

module tb_touch_keypad_serial_reader;
    import tksr_pkg::*;

    // One result transfer, from the lowest bit up: clock, busy, valid, timeout, keys.
    typedef struct packed {
        logic [15:0] keys;
        logic        timed_out;
        logic        result_valid;
        logic        busy;
        logic        clock_level;
    } t_reading;

    typedef struct packed {
        logic       level;
        logic       start;
        logic [4:0] reps;
        logic       fixed_result;
        t_reading   want;
    } t_row;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_TICKS = 106;

    // Directed ticks with zero timeout, half period, settle and gap, reading eight keys.
    localparam t_row DIRECTED [0:7] = '{
        '{1'b1, 1'b0, 5'd1,  1'b1, {16'h0000, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{1'b1, 1'b1, 5'd1,  1'b1, {16'h0000, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{1'b1, 1'b1, 5'd1,  1'b1, {16'h0000, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{1'b1, 1'b1, 5'd1,  1'b1, {16'h0000, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{1'b0, 1'b0, 5'd1,  1'b0, {16'h0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{1'b1, 1'b0, 5'd1,  1'b0, {16'h0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{1'b0, 1'b0, 5'd15, 1'b0, {16'h0000, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{1'b0, 1'b0, 5'd1,  1'b1, {16'h00FF, 1'b0, 1'b1, 1'b0, 1'b1}}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    logic        cfg_sixteen = 1'b1;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_timeout = RST_DETECT_TIMEOUT;
    logic [7:0]  cfg_half = RST_HALF_PERIOD;
    logic [9:0]  cfg_settle = RST_SETTLE_TICKS;
    logic [15:0] cfg_gap = RST_GAP_TICKS;

    logic [2:0]  ph = PH_IDLE;
    logic [15:0] cnt = '0;
    logic [4:0]  bitn = '0;
    logic [15:0] got = '0;
    logic [15:0] held_keys = '0;
    logic        clk_q = 1'b1;

    logic        calm = 1'b0;
    logic        clean_read = 1'b1;
    logic [15:0] touch_mask = '0;
    t_reading    pending_readings [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;

    touch_keypad_serial_reader dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void begin_clocking();
        ph = PH_CLK_LOW;
        cnt = '0;
        bitn = '0;
        got = '0;
        clk_q = 1'b0;
    endfunction

    function automatic void finish_reading();
        logic [15:0] value;
        value = got;
        if (cfg_index) begin
            value = '0;
            for (int i = 0; i < 16; i++) begin
                if (got[i]) begin
                    value = 16'(i + 1);
                end
            end
        end
        held_keys = value;
        ph = PH_IDLE;
        cnt = '0;
        clk_q = 1'b1;
    endfunction

    task automatic advance_reader(input logic d, input logic s, output t_reading r);
        logic [15:0] limit;
        logic [15:0] half;
        logic [4:0]  nbits;
        logic        done;
        logic        gave_up;
        limit = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
        half = (cfg_half == 8'd0) ? 16'd1 : {8'd0, cfg_half};
        nbits = cfg_sixteen ? 5'd16 : 5'd8;
        done = 1'b0;
        gave_up = 1'b0;
        case (ph)
            PH_IDLE: begin
                clk_q = 1'b1;
                if (s) begin
                    ph = PH_WAIT_LOW;
                    cnt = '0;
                    bitn = '0;
                    got = '0;
                end
            end
            PH_WAIT_LOW, PH_WAIT_HIGH: begin
                if (ph == PH_WAIT_LOW && !d) begin
                    ph = PH_WAIT_HIGH;
                end else if (ph == PH_WAIT_HIGH && d) begin
                    if (cfg_settle == 10'd0) begin
                        begin_clocking();
                    end else begin
                        ph = PH_SETTLE;
                        cnt = '0;
                    end
                end else begin
                    cnt = cnt + 16'd1;
                    if (cnt >= limit) begin
                        gave_up = 1'b1;
                        ph = PH_IDLE;
                        cnt = '0;
                        clk_q = 1'b1;
                    end
                end
            end
            PH_SETTLE: begin
                cnt = cnt + 16'd1;
                if (cnt >= {6'd0, cfg_settle}) begin
                    begin_clocking();
                end
            end
            PH_CLK_LOW: begin
                cnt = cnt + 16'd1;
                if (cnt >= half) begin
                    if (!d) begin
                        got[bitn[3:0]] = 1'b1;
                    end
                    clk_q = 1'b1;
                    ph = PH_CLK_HIGH;
                    cnt = '0;
                end
            end
            PH_CLK_HIGH: begin
                cnt = cnt + 16'd1;
                if (cnt >= half) begin
                    bitn = bitn + 5'd1;
                    if (bitn >= nbits) begin
                        if (cfg_gap == 16'd0) begin
                            finish_reading();
                            done = 1'b1;
                        end else begin
                            ph = PH_GAP;
                            cnt = '0;
                        end
                    end else begin
                        clk_q = 1'b0;
                        ph = PH_CLK_LOW;
                        cnt = '0;
                    end
                end
            end
            PH_GAP: begin
                cnt = cnt + 16'd1;
                if (cnt >= cfg_gap) begin
                    finish_reading();
                    done = 1'b1;
                end
            end
            default: begin
                ph = PH_IDLE;
                cnt = '0;
                clk_q = 1'b1;
            end
        endcase
        r = {held_keys, gave_up, done, ph != PH_IDLE, clk_q};
    endtask

    // The sensor side: clean reads answer the waits and present the touched keys.
    task automatic next_tick(output logic d, output logic s);
        d = 1'($urandom_range(0, 1));
        s = 1'($urandom_range(0, 1));
        case (ph)
            PH_IDLE: begin
                s = ($urandom_range(0, 3) == 0);
                if (s) begin
                    clean_read = ($urandom_range(0, 4) != 0);
                    case ($urandom_range(0, 5))
                        0: touch_mask = 16'h0000;
                        1: touch_mask = 16'hFFFF;
                        2: touch_mask = 16'h0001 << $urandom_range(0, 15);
                        default: touch_mask = 16'($urandom);
                    endcase
                end
            end
            PH_WAIT_LOW: begin
                if (clean_read) begin
                    d = ($urandom_range(0, 2) != 0);
                end
            end
            PH_CLK_LOW: begin
                if (clean_read) begin
                    d = !touch_mask[bitn[3:0]];
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic feed_tick(input logic d, input logic s, input logic fixed_result,
                             input t_reading want);
        t_reading predicted;
        advance_reader(d, s, predicted);
        pending_readings.push_back(fixed_result ? want : predicted);
        while (!calm && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, s, d};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_readings();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_SIXTEEN_KEYS:   cfg_sixteen = value[0];
            REG_REPORT_INDEX:   cfg_index = value[0];
            REG_DETECT_TIMEOUT: cfg_timeout = value;
            REG_HALF_PERIOD:    cfg_half = value[7:0];
            REG_SETTLE_TICKS:   cfg_settle = value[9:0];
            REG_GAP_TICKS:      cfg_gap = value;
            default: begin
            end
        endcase
    endtask

    task automatic apply_setup(input logic sixteen, input logic index, input logic [15:0] timeout,
                               input logic [7:0] half, input logic [9:0] settle,
                               input logic [15:0] gap);
        write_reg(REG_SIXTEEN_KEYS, {15'd0, sixteen});
        write_reg(REG_REPORT_INDEX, {15'd0, index});
        write_reg(REG_DETECT_TIMEOUT, timeout);
        write_reg(REG_HALF_PERIOD, {8'd0, half});
        write_reg(REG_SETTLE_TICKS, {6'd0, settle});
        write_reg(REG_GAP_TICKS, gap);
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] seen);
        if (want !== seen) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 36);
    end

    always @(posedge i_clk) begin : check_results
        t_reading want;
        t_reading seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = m_axis_tdata[19:0];
            if (pending_readings.size() == 0) begin
                $display("%0t: result %h arrived with none expected", $time, seen);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                check_field("clock_level", 16'(want.clock_level), 16'(seen.clock_level));
                check_field("busy", 16'(want.busy), 16'(seen.busy));
                check_field("result_valid", 16'(want.result_valid), 16'(seen.result_valid));
                check_field("timed_out", 16'(want.timed_out), 16'(seen.timed_out));
                check_field("keys", want.keys, seen.keys);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_touch_keypad_serial_reader: done, errors");
            $finish;
        end
    end

    initial begin
        logic d;
        logic s;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_setup(1'b0, 1'b0, 16'd0, 8'd0, 10'd0, 16'd0);
        for (int r = 0; r < 8; r++) begin
            for (int k = 0; k < DIRECTED[r].reps; k++) begin
                feed_tick(DIRECTED[r].level, DIRECTED[r].start, DIRECTED[r].fixed_result,
                          DIRECTED[r].want);
            end
        end

        // Each new setting lands on whatever the sequencer is doing, so waits get cut short.
        for (int p = 0; p < 8; p++) begin
            drain_readings();
            case (p)
                0: apply_setup(1'b1, 1'b0, 16'd8, 8'd1, 10'd0, 16'd0);
                1: apply_setup(1'b0, 1'b1, 16'd3, 8'd2, 10'd3, 16'd5);
                2: apply_setup(1'b1, 1'b0, 16'hFFFF, 8'hFF, 10'h3FF, 16'hFFFF);
                3: apply_setup(1'b0, 1'b0, 16'hFFFF, 8'd1, 10'd0, 16'hFFFF);
                4: apply_setup(1'b1, 1'b1, 16'd1, 8'd0, 10'd0, 16'd0);
                default: apply_setup(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     16'($urandom_range(0, 12)), 8'($urandom_range(0, 3)),
                                     10'($urandom_range(0, 6)), 16'($urandom_range(0, 8)));
            endcase
            calm = (p == 0);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (p == 1 && n == PHASE_TICKS / 2) begin
                    drain_readings();
                end
                next_tick(d, s);
                feed_tick(d, s, 1'b0, '0);
            end
        end

        drain_readings();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_touch_keypad_serial_reader: done, clean");
        end else begin
            $display("tb_touch_keypad_serial_reader: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/tksr_pkg.sv
rtl/core/tksr_cfg.sv
rtl/core/tksr_step.sv
rtl/core/touch_keypad_serial_reader.sv
tb/sv/tb_touch_keypad_serial_reader.sv
